// ----- src/ktd_pkg.sv -----
// ----------------------------------------------------------------------------
// Capacitive key touch detector package
// Shared types and constants for the front queue, the key engine and the top.
// ----------------------------------------------------------------------------
package ktd_pkg;

    localparam int KEY_W        = 4;
    localparam int READING_W    = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int WEIGHT_W     = 9;
    localparam int WEIGHT_SHIFT = 8;
    localparam int SAMPLE_MAX_W = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam int                  ROUND_HALF = 128;

    localparam logic [CFG_W-1:0]    THRESHOLD_RESET = 16'd20;
    localparam logic [CFG_W-1:0]    DEAD_ZONE_RESET = 16'd10;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 9'd64;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_CAL_SAMPLE = 2'd1,
        OP_CAL_FINISH = 2'd2,
        OP_DETECT     = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOUCH_THRESHOLD  = 2'd0,
        CFG_DEAD_ZONE        = 2'd1,
        CFG_SMOOTHING_WEIGHT = 2'd2,
        CFG_UNUSED           = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic             in_range;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0]    touch_threshold;
        logic [CFG_W-1:0]    dead_zone;
        logic [WEIGHT_W-1:0] smoothing_weight;
    } t_cfg;

endpackage

// ----- src/ktd_front.sv -----
// ----------------------------------------------------------------------------
// Touch detector front end
// Accepts input beats, classifies the key and sizes the reading, and holds
// them in a two-entry queue for the key engine.
// ----------------------------------------------------------------------------
module ktd_front #(
    parameter int KEY_COUNT   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_operation,
    input  logic [ktd_pkg::KEY_W-1:0]       i_key_index,
    input  logic [ktd_pkg::READING_W-1:0]   i_reading,
    output logic                            o_q_valid,
    output ktd_pkg::t_item                  o_q_item,
    output logic [SAMPLE_BITS-1:0]          o_q_sample,
    input  logic                            i_q_pop
);

    localparam int EXT_W = ktd_pkg::SAMPLE_MAX_W;

    ktd_pkg::t_item          r_item   [ktd_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]  r_sample [ktd_pkg::QUEUE_DEPTH];
    logic                    r_wr_ptr;
    logic                    r_rd_ptr;
    logic [1:0]              r_count;
    logic [1:0]              n_count;

    logic [EXT_W-1:0]        w_ext;
    ktd_pkg::t_item          w_item;
    logic                    w_push;

    assign w_ext           = EXT_W'(i_reading);
    assign w_item.op       = ktd_pkg::t_op'(i_operation);
    assign w_item.key      = i_key_index;
    assign w_item.in_range = (32'(i_key_index) < KEY_COUNT);

    assign o_stall    = (r_count == 2'(ktd_pkg::QUEUE_DEPTH));
    assign w_push     = i_valid && !o_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_item[r_rd_ptr];
    assign o_q_sample = r_sample[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item[r_wr_ptr]   <= w_item;
            r_sample[r_wr_ptr] <= w_ext[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- src/ktd_back.sv -----
// ----------------------------------------------------------------------------
// Touch detector key engine
// Holds per-key baseline, moving average and touched flag, applies one queued
// beat per cycle while the result is not stalled, and registers the result.
// ----------------------------------------------------------------------------
module ktd_back #(
    parameter int KEY_COUNT     = 16,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ktd_pkg::t_item              i_q_item,
    input  logic [SAMPLE_BITS-1:0]      i_q_sample,
    output logic                        o_q_pop,
    input  ktd_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ktd_pkg::KEY_W-1:0]   o_key_out,
    output logic                        o_touched,
    output logic                        o_press_event,
    output logic                        o_was_touched
);

    // Keys above the reach of the key field are never addressed.
    localparam int KEY_SPAN = 1 << ktd_pkg::KEY_W;
    localparam int DEPTH    = (KEY_COUNT < KEY_SPAN) ? KEY_COUNT : KEY_SPAN;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDE_W   = (SAMPLE_BITS > ktd_pkg::CFG_W) ? SAMPLE_BITS : ktd_pkg::CFG_W;
    localparam int AVG_W    = SAMPLE_BITS + FRACTION_BITS;
    localparam int REL_W    = WIDE_W + 1;
    localparam int CMP_W    = WIDE_W + FRACTION_BITS + 1;
    localparam int DIFF_W   = AVG_W + 1;
    localparam int PROD_W   = DIFF_W + ktd_pkg::WEIGHT_W + 1;

    logic [SAMPLE_BITS-1:0]    r_baseline [DEPTH];
    logic [AVG_W-1:0]          r_average  [DEPTH];
    logic [DEPTH-1:0]          r_flag;

    logic                      r_valid;
    logic [ktd_pkg::KEY_W-1:0] r_key_out;
    logic                      r_touched;
    logic                      r_press_event;
    logic                      r_was_touched;

    logic [IDX_W-1:0]          w_idx;
    logic [SAMPLE_BITS-1:0]    w_base;
    logic [AVG_W-1:0]          w_avg;
    logic                      w_flag;
    logic [AVG_W-1:0]          w_read_fx;
    logic [AVG_W-1:0]          w_base_fx;
    logic                      w_release;
    logic                      w_press;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_step;
    logic [AVG_W-1:0]          w_ema;

    logic [SAMPLE_BITS-1:0]    n_base;
    logic [AVG_W-1:0]          n_avg;
    logic                      n_flag;
    logic                      n_press;

    assign o_q_pop = i_q_valid && (!r_valid || !i_stall);

    assign w_idx     = IDX_W'(i_q_item.key);
    assign w_base    = r_baseline[w_idx];
    assign w_avg     = r_average[w_idx];
    assign w_flag    = r_flag[w_idx];
    assign w_read_fx = {i_q_sample, {FRACTION_BITS{1'b0}}};
    assign w_base_fx = {w_base, {FRACTION_BITS{1'b0}}};

    assign w_release = REL_W'(i_q_sample) < (REL_W'(w_base) + REL_W'(i_cfg.dead_zone));
    assign w_press   = CMP_W'(w_read_fx) >
                       (CMP_W'(w_avg) + CMP_W'({i_cfg.touch_threshold, {FRACTION_BITS{1'b0}}}));

    // Exponential step written as avg + w * (r - avg), rounded half up.
    assign w_diff = $signed({1'b0, w_read_fx}) - $signed({1'b0, w_avg});
    assign w_prod = PROD_W'($signed({1'b0, i_cfg.smoothing_weight})) * PROD_W'(w_diff);
    assign w_step = (w_prod + PROD_W'(ktd_pkg::ROUND_HALF)) >>> ktd_pkg::WEIGHT_SHIFT;
    assign w_ema  = w_avg + AVG_W'(w_step);

    always_comb begin
        n_base  = w_base;
        n_avg   = w_avg;
        n_flag  = w_flag;
        n_press = 1'b0;
        case (i_q_item.op)
            ktd_pkg::OP_CLEAR: begin
                n_base = '0;
                n_avg  = '0;
                n_flag = 1'b0;
            end
            ktd_pkg::OP_CAL_SAMPLE: begin
                if (i_q_sample > w_base) begin
                    n_base = i_q_sample;
                end
            end
            ktd_pkg::OP_CAL_FINISH: begin
                n_avg = w_base_fx;
            end
            ktd_pkg::OP_DETECT: begin
                if (w_release) begin
                    n_avg  = w_flag ? w_base_fx : w_ema;
                    n_flag = 1'b0;
                end else if (w_press) begin
                    n_avg   = w_read_fx;
                    n_flag  = 1'b1;
                    n_press = 1'b1;
                end else begin
                    n_avg = w_ema;
                end
            end
            default: begin
                n_avg = w_avg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_baseline[k] <= '0;
                r_average[k]  <= '0;
            end
            r_flag <= '0;
        end else if (o_q_pop && i_q_item.in_range) begin
            r_baseline[w_idx] <= n_base;
            r_average[w_idx]  <= n_avg;
            r_flag[w_idx]     <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_key_out     <= i_q_item.key;
            r_touched     <= i_q_item.in_range && n_flag;
            r_press_event <= i_q_item.in_range && n_press;
            r_was_touched <= i_q_item.in_range && n_press && w_flag;
        end
    end

    assign o_valid       = r_valid;
    assign o_key_out     = r_key_out;
    assign o_touched     = r_touched;
    assign o_press_event = r_press_event;
    assign o_was_touched = r_was_touched;

endmodule

// ----- src/capacitive_key_touch_detector.sv -----
// ----------------------------------------------------------------------------
// Capacitive key touch detector
// Per-key baseline calibration, moving average tracking and press detection.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_stall  i_operation, i_key_index, i_reading
//   result   out        o_valid / i_stall  o_key_out, o_touched,
//                                          o_press_event, o_was_touched
//   config   in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// One beat per cycle is sustained while the result is not stalled; a result
// is held first in the two-entry queue, then in the key engine's registers.
// The key engine reads, updates and writes key state in the same cycle with a
// single multiplier, so back-to-back beats on the same key see fresh state.
// Reset is synchronous and clears all key state and the queue at once.
// A stalled result holds while the queue takes up to two more beats.
// ----------------------------------------------------------------------------
module capacitive_key_touch_detector #(
    parameter int KEY_COUNT     = 16,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_operation,
    input  logic [ktd_pkg::KEY_W-1:0]         i_key_index,
    input  logic [ktd_pkg::READING_W-1:0]     i_reading,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ktd_pkg::KEY_W-1:0]         o_key_out,
    output logic                              o_touched,
    output logic                              o_press_event,
    output logic                              o_was_touched,
    input  logic                              i_cfg_wr_en,
    input  logic [ktd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ktd_pkg::CFG_W-1:0]         i_cfg_data
);

    ktd_pkg::t_cfg           r_cfg;
    logic                    q_valid;
    ktd_pkg::t_item          q_item;
    logic [SAMPLE_BITS-1:0]  q_sample;
    logic                    q_pop;
    logic [ktd_pkg::WEIGHT_W-1:0] w_weight_in;

    assign w_weight_in = i_cfg_data[ktd_pkg::WEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_threshold  <= ktd_pkg::THRESHOLD_RESET;
            r_cfg.dead_zone        <= ktd_pkg::DEAD_ZONE_RESET;
            r_cfg.smoothing_weight <= ktd_pkg::WEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            case (ktd_pkg::t_cfg_index'(i_cfg_index))
                ktd_pkg::CFG_TOUCH_THRESHOLD: begin
                    r_cfg.touch_threshold <= i_cfg_data;
                end
                ktd_pkg::CFG_DEAD_ZONE: begin
                    r_cfg.dead_zone <= i_cfg_data;
                end
                ktd_pkg::CFG_SMOOTHING_WEIGHT: begin
                    r_cfg.smoothing_weight <= (w_weight_in > ktd_pkg::WEIGHT_ONE) ?
                                              ktd_pkg::WEIGHT_ONE : w_weight_in;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    ktd_front #(
        .KEY_COUNT   (KEY_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_key_index (i_key_index),
        .i_reading   (i_reading),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .o_q_sample  (q_sample),
        .i_q_pop     (q_pop)
    );

    ktd_back #(
        .KEY_COUNT     (KEY_COUNT),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .i_q_sample    (q_sample),
        .o_q_pop       (q_pop),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_key_out     (o_key_out),
        .o_touched     (o_touched),
        .o_press_event (o_press_event),
        .o_was_touched (o_was_touched)
    );

    a_press_sets_touched : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_press_event |-> o_touched)
        else $error("press reported without touched state");

    a_was_needs_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_touched |-> o_press_event)
        else $error("was_touched reported without a press");

    a_accept_fills_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> q_valid)
        else $error("accepted beat missing from the queue");

    a_out_of_range_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (32'(o_key_out) >= KEY_COUNT) |-> !o_touched && !o_press_event)
        else $error("out of range key reported activity");

endmodule
